>>> rtl/wofap_pkg.sv
`timescale 1ns / 1ps

package wofap_pkg;

	localparam int NUM_TABLES_N = 6;
	localparam logic [2:0] NUM_TABLES = 3'd6;
	localparam logic [2:0] SAW_TABLE = 3'd2;
	localparam logic [2:0] WAVE_PULSE = 3'd6;

	localparam logic [14:0] PW_MIN = 15'd6554;
	localparam logic [14:0] PW_MAX = 15'd26214;
	localparam logic [14:0] PW_SPAN = 15'd19660;

	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_WAVE_SELECT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INCREMENT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FM_AMOUNT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 3'd4;

	localparam logic [2:0] RST_WAVE_SELECT = 3'd0;
	localparam logic [31:0] RST_PHASE_INCREMENT = 32'd39370534;
	localparam logic [14:0] RST_VOLUME_GAIN = 15'd32767;
	localparam logic [15:0] RST_FM_AMOUNT = 16'd0;
	localparam logic [14:0] RST_PULSE_WIDTH = 15'd16384;

	localparam int TABLE_INDEX_W = 10;
	localparam int SAMPLE_W = 16;
	localparam int VAL_W = 18;
	localparam int GAIN_W = 33;
	localparam int AM_W = 51;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FM,
		ST_PHASE,
		ST_POS,
		ST_RDA,
		ST_RDB,
		ST_INTERP,
		ST_ACC,
		ST_GAIN,
		ST_AM,
		ST_OUT
	} state_t;

endpackage

>>> rtl/wavetable_oscillator_fm_am_pwm.sv
`timescale 1ns / 1ps
// A sample tick runs FM, PHASE, the lookup states POS, RDA, RDB, INTERP and ACC, then GAIN,
// AM and OUT; pulse mode does two table lookups, and a wave select naming no waveform skips
// the lookup. Ticks are taken one at a time, set by the single read port of the table
// memory and the one shared lookup sequence; a table write is taken every cycle while idle.
// Reset clears the phase, the registers to their defaults and the handshake state; the table
// memory is not cleared and holds nothing defined until written.
module wavetable_oscillator_fm_am_pwm #(
	parameter int TABLE_SIZE = 1024,
	parameter int SAMPLE_BITS = 16,
	parameter int PHASE_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,

	input  logic in_valid,
	output logic in_ready,
	input  logic req_type,
	input  logic signed [wofap_pkg::SAMPLE_W-1:0] fm_sample,
	input  logic signed [wofap_pkg::SAMPLE_W-1:0] am_sample,
	input  logic signed [wofap_pkg::SAMPLE_W-1:0] pwm_sample,
	input  logic fm_connected,
	input  logic am_connected,
	input  logic pwm_connected,
	input  logic [2:0] table_select,
	input  logic [wofap_pkg::TABLE_INDEX_W-1:0] table_index,
	input  logic signed [wofap_pkg::SAMPLE_W-1:0] table_value,

	output logic out_valid,
	input  logic out_ready,
	output logic signed [SAMPLE_BITS-1:0] sample_out,

	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [wofap_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [wofap_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(TABLE_SIZE);
	localparam int MEM_DEPTH = wofap_pkg::NUM_TABLES_N * TABLE_SIZE;
	localparam int ADDR_W = $clog2(MEM_DEPTH);
	localparam int POS_W = PHASE_BITS + IDX_W;
	localparam int AM_W = wofap_pkg::AM_W;
	localparam logic signed [AM_W-1:0] LIM_HI =
		(AM_W'(1) <<< (SAMPLE_BITS - 1)) - AM_W'(1);
	localparam logic signed [AM_W-1:0] LIM_LO = -LIM_HI - AM_W'(1);

	wofap_pkg::state_t state_q, state_d;

	logic [2:0] wave_select_q;
	logic [31:0] phase_increment_q;
	logic [14:0] volume_gain_q;
	logic [15:0] fm_amount_q;
	logic [14:0] pulse_width_q;

	logic signed [15:0] fm_sample_q, am_sample_q, pwm_sample_q;
	logic fm_conn_q, am_conn_q, pwm_conn_q;

	logic [PHASE_BITS-1:0] phase_q, lph_q, fm_step_q;
	logic [14:0] pw_q;
	logic [IDX_W-1:0] idx_q;
	logic [15:0] frac_q;
	logic signed [15:0] a_q, rdata_q;
	logic signed [33:0] mul_q;
	logic signed [wofap_pkg::VAL_W-1:0] val_q;
	logic signed [wofap_pkg::GAIN_W-1:0] gain_q;
	logic signed [AM_W-1:0] am_q;
	logic pass_q;
	logic signed [SAMPLE_BITS-1:0] out_q;
	logic out_valid_q;

	logic signed [15:0] mem [MEM_DEPTH];

	logic in_accept, tick_accept, mem_we, out_fire, is_pulse;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [2:0] tbl;
	logic [IDX_W-1:0] nxt, rd_idx;
	logic signed [32:0] fm_off;
	logic [31:0] fm_q32;
	logic [15:0] pwm_u;
	logic [30:0] pwm_prod;
	logic [14:0] pw_mod, pw_clamp;
	logic [PHASE_BITS-1:0] phase_fm;
	logic [POS_W-1:0] pos;
	logic signed [16:0] diff;
	logic signed [33:0] mul_d, mul_sh;
	logic signed [wofap_pkg::VAL_W-1:0] interp_val;
	logic signed [17:0] amf;
	logic signed [AM_W-1:0] res_full;
	logic signed [SAMPLE_BITS-1:0] sat;

	assign in_ready = (state_q == wofap_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;

	assign in_accept = in_valid && in_ready;
	assign tick_accept = in_accept && !req_type;
	assign mem_we = in_accept && req_type && (table_select < wofap_pkg::NUM_TABLES)
		&& ({22'd0, table_index} < 32'(TABLE_SIZE));
	assign waddr = ADDR_W'(table_select) * ADDR_W'(TABLE_SIZE) + ADDR_W'(table_index);

	assign is_pulse = (wave_select_q == wofap_pkg::WAVE_PULSE);
	assign tbl = is_pulse ? wofap_pkg::SAW_TABLE : wave_select_q;
	assign nxt = (idx_q == IDX_W'(TABLE_SIZE - 1)) ? '0 : idx_q + 1'b1;
	assign rd_idx = (state_q == wofap_pkg::ST_RDB) ? nxt : idx_q;
	assign raddr = ADDR_W'(tbl) * ADDR_W'(TABLE_SIZE) + ADDR_W'(rd_idx);

	assign fm_off = $signed({1'b0, fm_amount_q}) * fm_sample_q;
	assign fm_q32 = {fm_off[29:0], 2'b00};
	assign pwm_u = {~pwm_sample_q[15], pwm_sample_q[14:0]};
	assign pwm_prod = pwm_u * wofap_pkg::PW_SPAN;
	assign pw_mod = wofap_pkg::PW_MIN + pwm_prod[30:16];
	assign pw_clamp = (pulse_width_q < wofap_pkg::PW_MIN) ? wofap_pkg::PW_MIN :
		(pulse_width_q > wofap_pkg::PW_MAX) ? wofap_pkg::PW_MAX : pulse_width_q;
	assign phase_fm = phase_q + (fm_conn_q ? fm_step_q : '0);

	assign pos = POS_W'(lph_q) * POS_W'(TABLE_SIZE);
	assign diff = rdata_q - a_q;
	assign mul_d = diff * $signed({1'b0, frac_q});
	assign mul_sh = mul_q >>> 16;
	assign interp_val = a_q + $signed(mul_sh[wofap_pkg::VAL_W-1:0]);

	assign amf = $signed({1'b0, ~am_sample_q[15], am_sample_q[14:0]});
	assign res_full = am_conn_q ? (am_q >>> 31)
		: ($signed({{(AM_W - wofap_pkg::GAIN_W){gain_q[wofap_pkg::GAIN_W-1]}}, gain_q}) >>> 15);
	assign sat = (res_full > LIM_HI) ? LIM_HI[SAMPLE_BITS-1:0] :
		(res_full < LIM_LO) ? LIM_LO[SAMPLE_BITS-1:0] : res_full[SAMPLE_BITS-1:0];

	assign out_fire = (state_q == wofap_pkg::ST_OUT) && (!out_valid_q || out_ready);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wofap_pkg::ST_IDLE: if (tick_accept) state_d = wofap_pkg::ST_FM;
			wofap_pkg::ST_FM: state_d = wofap_pkg::ST_PHASE;
			wofap_pkg::ST_PHASE: begin
				state_d = (wave_select_q > wofap_pkg::WAVE_PULSE) ? wofap_pkg::ST_GAIN
					: wofap_pkg::ST_POS;
			end
			wofap_pkg::ST_POS: state_d = wofap_pkg::ST_RDA;
			wofap_pkg::ST_RDA: state_d = wofap_pkg::ST_RDB;
			wofap_pkg::ST_RDB: state_d = wofap_pkg::ST_INTERP;
			wofap_pkg::ST_INTERP: state_d = wofap_pkg::ST_ACC;
			wofap_pkg::ST_ACC: begin
				state_d = (is_pulse && !pass_q) ? wofap_pkg::ST_POS : wofap_pkg::ST_GAIN;
			end
			wofap_pkg::ST_GAIN: state_d = wofap_pkg::ST_AM;
			wofap_pkg::ST_AM: state_d = wofap_pkg::ST_OUT;
			wofap_pkg::ST_OUT: if (out_fire) state_d = wofap_pkg::ST_IDLE;
			default: state_d = wofap_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wofap_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_select_q <= wofap_pkg::RST_WAVE_SELECT;
			phase_increment_q <= wofap_pkg::RST_PHASE_INCREMENT;
			volume_gain_q <= wofap_pkg::RST_VOLUME_GAIN;
			fm_amount_q <= wofap_pkg::RST_FM_AMOUNT;
			pulse_width_q <= wofap_pkg::RST_PULSE_WIDTH;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wofap_pkg::CFG_WAVE_SELECT: wave_select_q <= cfg_data[2:0];
				wofap_pkg::CFG_PHASE_INCREMENT: phase_increment_q <= cfg_data;
				wofap_pkg::CFG_VOLUME_GAIN: volume_gain_q <= cfg_data[14:0];
				wofap_pkg::CFG_FM_AMOUNT: fm_amount_q <= cfg_data[15:0];
				wofap_pkg::CFG_PULSE_WIDTH: pulse_width_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// Table writes land only while the sequencer is idle, so they never meet a lookup read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= table_value;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			out_valid_q <= 1'b0;
			pass_q <= 1'b0;
		end else begin
			if (state_q == wofap_pkg::ST_PHASE) begin
				phase_q <= phase_fm;
				pass_q <= 1'b0;
			end else if (out_fire) begin
				phase_q <= phase_q + phase_increment_q[31 -: PHASE_BITS];
			end
			if (state_q == wofap_pkg::ST_ACC) begin
				pass_q <= 1'b1;
			end
			if (out_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_accept) begin
			fm_sample_q <= fm_sample;
			am_sample_q <= am_sample;
			pwm_sample_q <= pwm_sample;
			fm_conn_q <= fm_connected;
			am_conn_q <= am_connected;
			pwm_conn_q <= pwm_connected;
		end
		unique case (state_q)
			wofap_pkg::ST_FM: begin
				fm_step_q <= fm_q32[31 -: PHASE_BITS];
				pw_q <= pwm_conn_q ? pw_mod : pw_clamp;
			end
			wofap_pkg::ST_PHASE: begin
				lph_q <= phase_fm;
				val_q <= '0;
			end
			wofap_pkg::ST_POS: begin
				idx_q <= pos[POS_W-1:PHASE_BITS];
				frac_q <= pos[PHASE_BITS-1 -: 16];
			end
			wofap_pkg::ST_RDB: a_q <= rdata_q;
			wofap_pkg::ST_INTERP: mul_q <= mul_d;
			wofap_pkg::ST_ACC: begin
				if (is_pulse && pass_q) begin
					val_q <= val_q - interp_val;
				end else begin
					val_q <= interp_val;
				end
				lph_q <= lph_q + {pw_q, {(PHASE_BITS - 15){1'b0}}};
			end
			wofap_pkg::ST_GAIN: gain_q <= val_q * $signed({1'b0, volume_gain_q});
			wofap_pkg::ST_AM: am_q <= gain_q * amf;
			wofap_pkg::ST_OUT: if (out_fire) out_q <= sat;
			default: ;
		endcase
	end

endmodule

>>> rtl/wofap_checker.sv
`timescale 1ns / 1ps

module wofap_checker #(
	parameter int SAMPLE_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic req_type,
	input logic out_valid,
	input logic out_ready,
	input logic signed [SAMPLE_BITS-1:0] sample_out
);

	// A waiting result holds until its transaction completes.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_out))
		else $error("result changed or dropped while stalled");

	// A sample tick occupies the block, so the next input must wait.
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !req_type |=> !in_ready)
		else $error("input taken again right after a sample tick");

	// A table write leaves the input side open.
	a_write_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && req_type |=> in_ready)
		else $error("table write stalled the input side");

	// A new result only appears at the end of a tick, while no input is taken.
	a_out_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_ready))
		else $error("result appeared without a tick in progress");

endmodule

bind wavetable_oscillator_fm_am_pwm wofap_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_wofap_checker (.*);
